// File: rtl/core/prl_pkg.sv
`timescale 1ns / 1ps
package prl_pkg;

  localparam int OP_W    = 3;
  localparam int POS_W   = 7;
  localparam int CNT_W   = 7;
  localparam int STAT_W  = 2;
  localparam int NAME_W  = 64;

  localparam logic [OP_W-1:0] OP_INSERT  = 3'd0;
  localparam logic [OP_W-1:0] OP_REMOVE  = 3'd1;
  localparam logic [OP_W-1:0] OP_MODIFY  = 3'd2;
  localparam logic [OP_W-1:0] OP_OBSERVE = 3'd3;
  localparam logic [OP_W-1:0] OP_FIND    = 3'd4;
  localparam logic [OP_W-1:0] OP_CLEAR   = 3'd5;

  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_RANGE    = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL     = 2'd2;
  localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd3;

  typedef logic [2:0] cmd_t;
  localparam cmd_t CMD_HOLD = 3'd0;
  localparam cmd_t CMD_INS  = 3'd1;
  localparam cmd_t CMD_REM  = 3'd2;
  localparam cmd_t CMD_MOD  = 3'd3;
  localparam cmd_t CMD_ROT  = 3'd4;

  typedef struct packed {
    logic signed [31:0] id;
    logic [7:0]         age;
    logic [NAME_W-1:0]  first;
    logic [NAME_W-1:0]  last;
  } rec_t;

  // Keeps at most nbytes bytes and zeroes everything from the first zero byte.
  function automatic logic [NAME_W-1:0] cut_name(input logic [NAME_W-1:0] text,
                                                 input int nbytes);
    logic [NAME_W-1:0] kept;
    logic alive;
    kept  = '0;
    alive = 1'b1;
    for (int b = 0; b < 8; b++) begin
      if (b >= nbytes || text[8*b +: 8] == 8'd0) begin
        alive = 1'b0;
      end
      if (alive) begin
        kept[8*b +: 8] = text[8*b +: 8];
      end
    end
    return kept;
  endfunction

endpackage

// File: rtl/core/prl_cell.sv
`timescale 1ns / 1ps
module prl_cell
  import prl_pkg::*;
#(
  parameter int IDX = 0,
  parameter int IW  = 6
) (
  input  logic          clk,
  input  cmd_t          cmd,
  input  logic [IW-1:0] sel,
  input  rec_t          new_rec,
  input  rec_t          left_rec,
  input  rec_t          right_rec,
  output rec_t          rec_q
);

  localparam logic [IW-1:0] ME = IW'(IDX);

  rec_t rec_r;
  rec_t rec_nxt;

  always_comb begin
    rec_nxt = rec_r;
    unique case (cmd)
      CMD_INS: begin
        if (ME > sel) rec_nxt = left_rec;
        else if (ME == sel) rec_nxt = new_rec;
      end
      CMD_REM: begin
        if (ME >= sel) rec_nxt = right_rec;
      end
      CMD_MOD: begin
        if (ME == sel) rec_nxt = new_rec;
      end
      CMD_ROT:  rec_nxt = right_rec;
      default:  rec_nxt = rec_r;
    endcase
  end

  always_ff @(posedge clk) begin
    rec_r <= rec_nxt;
  end

  assign rec_q = rec_r;

endmodule

// File: rtl/core/positional_record_list.sv
`timescale 1ns / 1ps
// Positional record list: an ordered list of up to CAPACITY records, each with
// an identifier, an age and two packed names. Requests arrive as beats on the
// in_ channel (in_valid / in_stall) and each produces exactly one result beat
// on the out_ channel (out_valid / out_stall). A beat moves on a rising edge
// where valid is high and stall is low.
// The records sit in a row of cells, cell k holding list position k+1.
// Insert, remove and modify shift or load the row at once; their result, like
// that of clear or of a rejected request, is registered at the accepting edge
// and shows in the next cycle; such requests can follow each other in every
// cycle while the receiver takes them. Observe and find that pass their checks
// rotate the whole row once around, one cell per cycle, looking at cell zero;
// a finish step then loads the result into the output register, and the next
// request can be taken in the cycle the result shows if the receiver takes it.
// One request is in flight at a time. in_stall is high during a rotation and
// while a finished result waits on a stalled receiver; the result register
// then holds its beat unchanged until it is taken.
// Reset (rst_n low, synchronous) empties the list and drops any pending
// result; record contents are not cleared, only the count and the control.
module positional_record_list
  import prl_pkg::*;
#(
  parameter int CAPACITY   = 64,
  parameter int NAME_BYTES = 8
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [OP_W-1:0]          in_op,
  input  logic [POS_W-1:0]         in_position,
  input  logic signed [31:0]       in_record_id,
  input  logic [7:0]               in_record_age,
  input  logic [NAME_W-1:0]        in_first_name_text,
  input  logic [NAME_W-1:0]        in_last_name_text,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [STAT_W-1:0]        out_status,
  output logic signed [31:0]       out_id,
  output logic [7:0]               out_age,
  output logic [NAME_W-1:0]        out_first_name,
  output logic [NAME_W-1:0]        out_last_name,
  output logic [POS_W-1:0]         out_found_position,
  output logic [CNT_W-1:0]         out_entry_count,
  output logic                     out_list_empty
);

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = ((CW > POS_W) ? CW : POS_W) + 1;
  localparam logic [CW-1:0] CAP_C  = CW'(CAPACITY);
  localparam logic [IW-1:0] LAST_K = IW'(CAPACITY - 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  logic [1:0]    state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [IW-1:0] step_r;
  logic [IW-1:0] sel_r;
  logic [OP_W-1:0] op_r;
  logic signed [31:0] want_r;

  // Scan results collected during a rotation.
  rec_t              hrec_r;
  logic [STAT_W-1:0] hstat_r;
  logic [POS_W-1:0]  hfound_r;

  // Output register.
  logic              out_valid_r;
  logic [STAT_W-1:0] ostat_r;
  rec_t              orec_r;
  logic [POS_W-1:0]  ofound_r;
  logic [CW-1:0]     ocnt_r;

  logic acc, out_free, load_imm, start_scan;
  logic [STAT_W-1:0] imm_stat;
  cmd_t cmd;
  logic [IW-1:0] sel_now;
  logic [PW-1:0] pos_e, cnt_e;
  rec_t new_rec;
  rec_t cell_q [CAPACITY];

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != S_IDLE) || !out_free;
  assign acc      = in_valid && !in_stall;

  assign pos_e   = PW'(in_position);
  assign cnt_e   = PW'(count_r);
  assign sel_now = IW'(in_position - POS_W'(1));

  assign new_rec.id    = in_record_id;
  assign new_rec.age   = in_record_age;
  assign new_rec.first = cut_name(in_first_name_text, NAME_BYTES);
  assign new_rec.last  = cut_name(in_last_name_text, NAME_BYTES);

  // Request decode and validation at the accepting edge.
  always_comb begin
    cmd        = CMD_HOLD;
    imm_stat   = ST_OK;
    load_imm   = 1'b0;
    start_scan = 1'b0;
    count_nxt  = count_r;
    if (state_r == S_SCAN) begin
      cmd = CMD_ROT;
    end
    if (acc) begin
      load_imm = 1'b1;
      unique case (in_op)
        OP_INSERT: begin
          priority if (count_r == CAP_C) imm_stat = ST_FULL;
          else if (pos_e == '0 || pos_e > cnt_e + PW'(1)) imm_stat = ST_RANGE;
          else begin
            cmd       = CMD_INS;
            count_nxt = count_r + CW'(1);
          end
        end
        OP_REMOVE, OP_MODIFY, OP_OBSERVE: begin
          priority if (count_r == '0) imm_stat = ST_NOTFOUND;
          else if (pos_e == '0 || pos_e > cnt_e) imm_stat = ST_RANGE;
          else begin
            priority if (in_op == OP_REMOVE) begin
              cmd       = CMD_REM;
              count_nxt = count_r - CW'(1);
            end else if (in_op == OP_MODIFY) begin
              cmd = CMD_MOD;
            end else begin
              load_imm   = 1'b0;
              start_scan = 1'b1;
            end
          end
        end
        OP_FIND: begin
          if (count_r == '0) imm_stat = ST_NOTFOUND;
          else begin
            load_imm   = 1'b0;
            start_scan = 1'b1;
          end
        end
        OP_CLEAR: count_nxt = '0;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (start_scan) state_nxt = S_SCAN;
      S_SCAN:  if (step_r == LAST_K) state_nxt = S_FIN;
      S_FIN:   if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      step_r      <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (load_imm || (state_r == S_FIN && out_free)) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == S_SCAN) begin
        step_r <= step_r + IW'(1);
      end else begin
        step_r <= '0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (start_scan) begin
      op_r     <= in_op;
      sel_r    <= sel_now;
      want_r   <= in_record_id;
      hrec_r   <= '0;
      hfound_r <= '0;
      hstat_r  <= (in_op == OP_OBSERVE) ? ST_OK : ST_NOTFOUND;
    end else if (state_r == S_SCAN) begin
      // Cell zero holds list position step_r + 1 in this cycle.
      if (op_r == OP_OBSERVE) begin
        if (step_r == sel_r) hrec_r <= cell_q[0];
      end else if (hstat_r == ST_NOTFOUND && CW'(step_r) < count_r &&
                   cell_q[0].id == want_r) begin
        hfound_r <= POS_W'({1'b0, step_r} + (IW+1)'(1));
        hstat_r  <= ST_OK;
      end
    end
    if (load_imm) begin
      ostat_r  <= imm_stat;
      orec_r   <= '0;
      ofound_r <= '0;
      ocnt_r   <= count_nxt;
    end else if (state_r == S_FIN && out_free) begin
      ostat_r  <= hstat_r;
      orec_r   <= hrec_r;
      ofound_r <= hfound_r;
      ocnt_r   <= count_r;
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    localparam int LI = (i == 0) ? CAPACITY - 1 : i - 1;
    localparam int RI = (i == CAPACITY - 1) ? 0 : i + 1;
    prl_cell #(
      .IDX(i),
      .IW (IW)
    ) u_cell (
      .clk      (clk),
      .cmd      (cmd),
      .sel      (sel_now),
      .new_rec  (new_rec),
      .left_rec (cell_q[LI]),
      .right_rec(cell_q[RI]),
      .rec_q    (cell_q[i])
    );
  end

  assign out_valid          = out_valid_r;
  assign out_status         = ostat_r;
  assign out_id             = orec_r.id;
  assign out_age            = orec_r.age;
  assign out_first_name     = orec_r.first;
  assign out_last_name      = orec_r.last;
  assign out_found_position = ofound_r;
  assign out_entry_count    = CNT_W'(ocnt_r);
  assign out_list_empty     = (ocnt_r == '0);

  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CAP_C) else $error("count above capacity");

  a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> in_stall) else $error("request taken while busy");

  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && in_op == OP_CLEAR) |=> (count_r == '0)) else $error("clear left records");

  a_scan_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && out_free) |=> out_valid) else $error("scan result lost");

endmodule
